// ===== rtl/core/lsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lsm_pkg;

    localparam int SLOTS      = 64;
    localparam int TIME_BITS  = 48;
    localparam int COUNT_BITS = 32;
    localparam int SLOT_W     = 6;
    localparam int OUT_TIME_W = 48;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int DIV_CNT_W  = $clog2(TIME_BITS + 1);

    localparam logic [1:0] FUNC_ENTER = 2'd0;
    localparam logic [1:0] FUNC_EXIT  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [TIME_BITS-1:0]  TIME_ONES = '1;

    typedef logic [TIME_BITS-1:0] time_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        time_t                 min_t;
        time_t                 max_t;
        time_t                 mean_t;
    } stats_t;

    localparam stats_t STATS_RESET = '{
        count:  '0,
        min_t:  TIME_ONES,
        max_t:  '0,
        mean_t: '0
    };

    typedef struct packed {
        logic accept;
        logic eval;
        logic emit;
        logic div_start;
        logic writeback;
    } lsm_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } lsm_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/lsm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsm_div
    import lsm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire time_t                 dividend,
    input  wire logic [COUNT_BITS-1:0] divisor,
    output time_t                      quotient,
    output logic                       done
);

    logic                  run_reg, run_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    time_t                 quo_reg, quo_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [COUNT_BITS-1:0] dsr_reg, dsr_next;
    logic [COUNT_BITS:0]   rem_sh;
    logic [COUNT_BITS:0]   trial;
    logic                  fits;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[TIME_BITS-1]};
        fits     = rem_sh >= {1'b0, dsr_reg};
        trial    = rem_sh - {1'b0, dsr_reg};
        run_next = run_reg;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = DIV_CNT_W'(TIME_BITS);
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (run_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - 1'b1;
                quo_next = {quo_reg[TIME_BITS-2:0], fits};
                rem_next = fits ? trial[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
            end
            else
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = run_reg && (cnt_reg == '0);

endmodule

`default_nettype wire

// ===== rtl/core/lsm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsm_ctrl
    import lsm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [1:0]  func,
    input  wire lsm_status_t status,
    output lsm_cmd_t         cmd,
    output logic             busy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_WB   = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.accept    = start && (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                // enter and clear finish at the accept edge
                if (cmd.accept && (func == FUNC_EXIT || func == FUNC_READ))
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (status.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_WB;
            end
            S_WB:
            begin
                cmd.writeback = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/lsm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsm_datapath
    import lsm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire lsm_cmd_t               cmd,
    output lsm_status_t                 status,
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_wdata,
    input  wire logic [1:0]             func,
    input  wire logic [SLOT_W-1:0]      slot,
    input  wire logic [TIME_BITS-1:0]   timestamp,
    output logic                        done,
    output logic [SLOT_W-1:0]           slot_out,
    output logic [COUNT_BITS-1:0]       sample_count,
    output logic [OUT_TIME_W-1:0]       shortest,
    output logic [OUT_TIME_W-1:0]       longest,
    output logic [OUT_TIME_W-1:0]       mean_time,
    output logic [OUT_TIME_W-1:0]       last_elapsed,
    output logic                        recorded
);

    time_t  enter_mem [SLOTS];
    stats_t stats_mem [SLOTS];

    logic [SLOTS-1:0] ent_vld_reg, ent_vld_next;
    logic [SLOTS-1:0] st_vld_reg, st_vld_next;
    logic             rec_on_reg;

    logic [1:0]            func_reg;
    logic [SLOT_W-1:0]     slot_reg;
    time_t                 ts_reg;
    time_t                 ent_rd_reg;
    stats_t                st_rd_reg;
    logic                  ent_hit_reg;
    logic                  st_hit_reg;

    stats_t                st_hold_reg;
    time_t                 el_reg;
    logic                  ge_reg;
    logic [COUNT_BITS-1:0] cnew_reg;
    time_t                 diff_reg;

    logic [IDX_W-1:0] in_idx;
    logic [IDX_W-1:0] cur_idx;
    logic             in_ok;
    logic             cur_ok;
    time_t            ent_eff;
    stats_t           st_eff;
    time_t            el;
    logic             ge;
    time_t            diff;
    logic [COUNT_BITS-1:0] cnew;
    time_t            quotient;
    logic             div_done;
    stats_t           st_new;

    logic                   done_reg;
    logic [SLOT_W-1:0]      o_slot_reg;
    logic [COUNT_BITS-1:0]  o_cnt_reg;
    time_t                  o_min_reg;
    time_t                  o_max_reg;
    time_t                  o_mean_reg;
    time_t                  o_el_reg;
    logic                   o_rec_reg;

    assign in_idx  = slot[IDX_W-1:0];
    assign cur_idx = slot_reg[IDX_W-1:0];
    assign in_ok   = {1'b0, slot} < (SLOT_W + 1)'(SLOTS);
    assign cur_ok  = {1'b0, slot_reg} < (SLOT_W + 1)'(SLOTS);

    // an entry never written since reset or clear reads as its reset value
    always_comb
    begin
        ent_eff = ent_hit_reg ? ent_rd_reg : '0;
        st_eff  = st_hit_reg ? st_rd_reg : STATS_RESET;
        el      = ts_reg - ent_eff;
        ge      = el >= st_eff.mean_t;
        diff    = ge ? (el - st_eff.mean_t) : (st_eff.mean_t - el);
        cnew    = (st_eff.count != COUNT_MAX) ? st_eff.count + 1'b1 : st_eff.count;
    end

    assign status.need_div = (func_reg == FUNC_EXIT) && cur_ok && rec_on_reg;
    assign status.div_done = div_done;

    lsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (diff),
        .divisor  (cnew),
        .quotient (quotient),
        .done     (div_done)
    );

    always_comb
    begin
        st_new.count  = cnew_reg;
        st_new.mean_t = ge_reg ? (st_hold_reg.mean_t + quotient)
                               : (st_hold_reg.mean_t - quotient);
        st_new.max_t  = (el_reg > st_hold_reg.max_t) ? el_reg : st_hold_reg.max_t;
        st_new.min_t  = (el_reg < st_hold_reg.min_t) ? el_reg : st_hold_reg.min_t;
    end

    always_comb
    begin
        ent_vld_next = ent_vld_reg;
        st_vld_next  = st_vld_reg;
        if (cmd.accept && func == FUNC_CLEAR)
        begin
            ent_vld_next = '0;
            st_vld_next  = '0;
        end
        else if (cmd.accept && func == FUNC_ENTER && in_ok)
        begin
            ent_vld_next[in_idx] = 1'b1;
        end
        if (cmd.writeback)
            st_vld_next[cur_idx] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_vld_reg <= '0;
            st_vld_reg  <= '0;
            rec_on_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            ent_vld_reg <= ent_vld_next;
            st_vld_reg  <= st_vld_next;
            if (cfg_we)
                rec_on_reg <= cfg_wdata;
            done_reg <= cmd.emit || cmd.writeback;
        end
    end

    // table memories: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.accept && func == FUNC_ENTER && in_ok)
            enter_mem[in_idx] <= timestamp;
        if (cmd.accept)
            ent_rd_reg <= enter_mem[in_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.writeback)
            stats_mem[cur_idx] <= st_new;
        if (cmd.accept)
            st_rd_reg <= stats_mem[in_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg    <= func;
            slot_reg    <= slot;
            ts_reg      <= timestamp;
            ent_hit_reg <= ent_vld_reg[in_idx];
            st_hit_reg  <= st_vld_reg[in_idx];
        end
        if (cmd.div_start)
        begin
            st_hold_reg <= st_eff;
            el_reg      <= el;
            ge_reg      <= ge;
            cnew_reg    <= cnew;
            diff_reg    <= diff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            o_slot_reg <= slot_reg;
            if (!cur_ok)
            begin
                o_cnt_reg  <= '0;
                o_min_reg  <= TIME_ONES;
                o_max_reg  <= '0;
                o_mean_reg <= '0;
                o_el_reg   <= '0;
            end
            else
            begin
                o_cnt_reg  <= st_eff.count;
                o_min_reg  <= st_eff.min_t;
                o_max_reg  <= st_eff.max_t;
                o_mean_reg <= st_eff.mean_t;
                o_el_reg   <= (func_reg == FUNC_EXIT) ? el : '0;
            end
            o_rec_reg <= 1'b0;
        end
        else if (cmd.writeback)
        begin
            o_slot_reg <= slot_reg;
            o_cnt_reg  <= st_new.count;
            o_min_reg  <= st_new.min_t;
            o_max_reg  <= st_new.max_t;
            o_mean_reg <= st_new.mean_t;
            o_el_reg   <= el_reg;
            // magnitude must dominate the quotient, otherwise the mean would wrap
            o_rec_reg  <= (diff_reg >= quotient);
        end
    end

    assign done         = done_reg;
    assign slot_out     = o_slot_reg;
    assign sample_count = o_cnt_reg;
    assign shortest     = OUT_TIME_W'(o_min_reg);
    assign longest      = OUT_TIME_W'(o_max_reg);
    assign mean_time    = OUT_TIME_W'(o_mean_reg);
    assign last_elapsed = OUT_TIME_W'(o_el_reg);
    assign recorded     = o_rec_reg;

endmodule

`default_nettype wire

// ===== rtl/core/latency_stats_monitor.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel      signals                                   transaction on
// ----------   ---------------------------------------   ----------------------
// command      start busy func slot timestamp            start && !busy
// result       done slot_out sample_count shortest       done (one cycle)
//              longest mean_time last_elapsed recorded
// config       cfg_we cfg_wdata (recording_on)           cfg_we
//
// enter and clear complete at the accept edge; busy stays low.
// read, and exit with recording off, pass through the eval state; done is registered.
// a recorded exit also waits for the 48-step shift-subtract divider, which
// divides the mean correction by the new sample count.
// clear resets all slots at the accept edge through per-slot valid bits; no sweep.
// results cannot be stalled; each is shown for exactly one cycle.

module latency_stats_monitor
    import lsm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_wdata,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            func,
    input  wire logic [SLOT_W-1:0]     slot,
    input  wire logic [TIME_BITS-1:0]  timestamp,
    output logic                       done,
    output logic [SLOT_W-1:0]          slot_out,
    output logic [COUNT_BITS-1:0]      sample_count,
    output logic [OUT_TIME_W-1:0]      shortest,
    output logic [OUT_TIME_W-1:0]      longest,
    output logic [OUT_TIME_W-1:0]      mean_time,
    output logic [OUT_TIME_W-1:0]      last_elapsed,
    output logic                       recorded
);

    lsm_cmd_t    cmd;
    lsm_status_t status;

    lsm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    lsm_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .func         (func),
        .slot         (slot),
        .timestamp    (timestamp),
        .done         (done),
        .slot_out     (slot_out),
        .sample_count (sample_count),
        .shortest     (shortest),
        .longest      (longest),
        .mean_time    (mean_time),
        .last_elapsed (last_elapsed),
        .recorded     (recorded)
    );

endmodule

`default_nettype wire

// ===== rtl/core/lsm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsm_checker
    import lsm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_wdata,
    input  wire logic                  start,
    input  wire logic                  busy,
    input  wire logic [1:0]            func,
    input  wire logic [SLOT_W-1:0]     slot,
    input  wire logic [TIME_BITS-1:0]  timestamp,
    input  wire logic                  done,
    input  wire logic [SLOT_W-1:0]     slot_out,
    input  wire logic [COUNT_BITS-1:0] sample_count,
    input  wire logic [OUT_TIME_W-1:0] shortest,
    input  wire logic [OUT_TIME_W-1:0] longest,
    input  wire logic [OUT_TIME_W-1:0] mean_time,
    input  wire logic [OUT_TIME_W-1:0] last_elapsed,
    input  wire logic                  recorded
);

    // a result is shown only once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // enter and clear finish without a result
    a_quiet_funcs: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == FUNC_ENTER || func == FUNC_CLEAR))
        |=> (!busy && !done))
        else $error("enter or clear produced activity");

    // exit and read raise busy in the cycle after they are accepted
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == FUNC_EXIT || func == FUNC_READ)) |=> busy)
        else $error("exit or read not taken up");

    a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // a recorded sample leaves a consistent range
    a_rec_stats: assert property (@(posedge clk) disable iff (!rst_n)
        (done && recorded) |-> (sample_count != '0 && shortest <= longest
                                && shortest <= mean_time && mean_time <= longest))
        else $error("recorded statistics out of order");

endmodule

bind latency_stats_monitor lsm_checker u_lsm_checker (.*);

`default_nettype wire
